### hdl/utf8d_pkg.sv
`timescale 1ns / 1ps
// utf8d_pkg: shared types and constants for the streaming utf-8 decoder
// used by utf8_stream_decoder and its port checker; no dependencies

package utf8d_pkg;

	localparam int CpWidth = 21;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEAD  = 3'd1,
		ST_BAD_CONT  = 3'd2,
		ST_TRUNC     = 3'd3,
		ST_RANGE     = 3'd4,
		ST_OVERLONG  = 3'd5
	} status_t;

	typedef struct packed {
		logic [CpWidth-1:0] cp;
		status_t            st;
		logic               last;
	} result_t;

	localparam logic [CpWidth-1:0] SurrLo   = 21'h00D800;
	localparam logic [CpWidth-1:0] SurrHi   = 21'h00E000;
	localparam logic [CpWidth-1:0] CpLimit  = 21'h110000;
	localparam logic [CpWidth-1:0] Bound2   = 21'h000080;
	localparam logic [CpWidth-1:0] Bound3   = 21'h000800;
	localparam logic [CpWidth-1:0] Bound4   = 21'h010000;

endpackage

### hdl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// utf8_stream_decoder: byte-at-a-time utf-8 decoder with validation
// depends on utf8d_pkg
//
// usage:
//   byte channel: text_byte and end_of_text, with byte_valid / byte_stall.
//   an item is taken at a clock edge with valid high and stall low.
//   result channel: code_point, status, last_of_run, with result_valid /
//   result_stall. each byte gives zero, one or two results; last_of_run
//   marks the final result caused by a byte.
// timing:
//   an accepted byte sits in the input register, then the decode logic
//   writes all its results together into a two-entry result queue and the
//   first is shown at the queue head; a second result from the same byte
//   follows once the first is taken.
//   one byte per cycle is sustained while the receiver takes results; a byte
//   that gives two results holds the input register only while the queue
//   lacks room for both.
// stall / reset:
//   when the receiver stalls, the queue fills and byte_stall rises as soon as
//   the pending byte cannot place all its results; nothing is dropped.
//   arst_n clears the open sequence, the input register and the queue.

module utf8_stream_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	output logic                           byte_stall,
	input  logic [7:0]                     text_byte,
	input  logic                           end_of_text,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [utf8d_pkg::CpWidth-1:0]  code_point,
	output utf8d_pkg::status_t             status,
	output logic                           last_of_run
);
	import utf8d_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;

	// open sequence state
	logic [CpWidth-1:0] pv_q;
	logic [1:0]         rem_q;
	logic [2:0]         len_q;

	// result queue
	result_t    ent_q [2];
	result_t    ent_d [2];
	logic [1:0] cnt_q;
	logic [1:0] cnt_d;

	// decode outputs
	result_t            r0, r1;
	logic [1:0]         n_res;
	logic [CpWidth-1:0] pv_d;
	logic [1:0]         rem_d;
	logic [2:0]         len_d;

	// start-of-sequence handling of the byte
	logic               s_emit;
	logic [CpWidth-1:0] s_cp;
	status_t            s_st;
	logic [CpWidth-1:0] s_pv;
	logic [1:0]         s_rem;
	logic [2:0]         s_len;

	logic               is_cont;
	logic [CpWidth-1:0] pv_cat;
	logic [1:0]         rem_dec;

	logic       pop, proc;
	logic [1:0] base;
	logic [2:0] fill;

	function automatic status_t check_value(input logic [CpWidth-1:0] cp,
	                                        input logic [2:0] len);
		logic [2:0] need;
		begin
			need = 3'd1 + {2'b00, cp >= Bound2} + {2'b00, cp >= Bound3}
			     + {2'b00, cp >= Bound4};
			if ((cp >= SurrLo && cp < SurrHi) || cp >= CpLimit) begin
				check_value = ST_RANGE;
			end else if (need != len) begin
				check_value = ST_OVERLONG;
			end else begin
				check_value = ST_OK;
			end
		end
	endfunction

	always_comb begin
		s_emit = 1'b0;
		s_cp   = '0;
		s_st   = ST_OK;
		s_pv   = '0;
		s_rem  = 2'd0;
		s_len  = 3'd0;
		if (!byte_s1[7]) begin
			s_emit = 1'b1;
			s_cp   = {{(CpWidth-8){1'b0}}, byte_s1};
		end else if (byte_s1 < 8'hC0 || byte_s1 >= 8'hF8) begin
			s_emit = 1'b1;
			s_st   = ST_BAD_LEAD;
		end else begin
			if (byte_s1 >= 8'hF0) begin
				s_len = 3'd4;
				s_pv  = {{(CpWidth-3){1'b0}}, byte_s1[2:0]};
			end else if (byte_s1 >= 8'hE0) begin
				s_len = 3'd3;
				s_pv  = {{(CpWidth-4){1'b0}}, byte_s1[3:0]};
			end else begin
				s_len = 3'd2;
				s_pv  = {{(CpWidth-5){1'b0}}, byte_s1[4:0]};
			end
			s_rem = s_len[1:0] - 2'd1;
			// truncated right at the lead byte
			if (eot_s1) begin
				s_emit = 1'b1;
				s_st   = ST_TRUNC;
				s_pv   = '0;
				s_rem  = 2'd0;
				s_len  = 3'd0;
			end
		end
	end

	assign is_cont = (byte_s1[7:6] == 2'b10);
	assign pv_cat  = {pv_q[CpWidth-7:0], byte_s1[5:0]};
	assign rem_dec = rem_q - 2'd1;

	always_comb begin
		r0    = '{cp: '0, st: ST_OK, last: 1'b1};
		r1    = '{cp: '0, st: ST_OK, last: 1'b1};
		n_res = 2'd0;
		pv_d  = pv_q;
		rem_d = rem_q;
		len_d = len_q;
		if (rem_q == 2'd0) begin
			r0.cp = s_cp;
			r0.st = s_st;
			n_res = {1'b0, s_emit};
			pv_d  = s_pv;
			rem_d = s_rem;
			len_d = s_len;
		end else if (is_cont) begin
			pv_d  = pv_cat;
			rem_d = rem_dec;
			if (rem_dec == 2'd0) begin
				r0.st = check_value(pv_cat, len_q);
				r0.cp = (r0.st == ST_OK) ? pv_cat : '0;
				n_res = 2'd1;
				pv_d  = '0;
				len_d = 3'd0;
			end else if (eot_s1) begin
				r0.st = ST_TRUNC;
				n_res = 2'd1;
				pv_d  = '0;
				rem_d = 2'd0;
				len_d = 3'd0;
			end
		end else begin
			// broken sequence, then the byte starts over
			r0.st   = ST_BAD_CONT;
			r0.last = ~s_emit;
			r1.cp   = s_cp;
			r1.st   = s_st;
			n_res   = s_emit ? 2'd2 : 2'd1;
			pv_d    = s_pv;
			rem_d   = s_rem;
			len_d   = s_len;
		end
	end

	assign result_valid = (cnt_q != 2'd0);
	assign pop          = result_valid & ~result_stall;
	assign base         = cnt_q - {1'b0, pop};
	assign fill         = {1'b0, base} + {1'b0, n_res};
	assign proc         = valid_s1 & (fill <= 3'd2);
	assign byte_stall   = valid_s1 & ~proc;

	assign code_point  = ent_q[0].cp;
	assign status      = ent_q[0].st;
	assign last_of_run = ent_q[0].last;

	always_comb begin
		ent_d[0] = ent_q[0];
		ent_d[1] = ent_q[1];
		cnt_d    = base;
		if (pop) begin
			ent_d[0] = ent_q[1];
		end
		if (proc) begin
			cnt_d = fill[1:0];
			if (n_res != 2'd0) begin
				ent_d[base[0]] = r0;
			end
			if (n_res == 2'd2) begin
				ent_d[1] = r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= 2'd0;
			pv_q     <= '0;
			rem_q    <= 2'd0;
			len_q    <= 3'd0;
		end else begin
			cnt_q <= cnt_d;
			if (proc) begin
				pv_q  <= pv_d;
				rem_q <= rem_d;
				len_q <= len_d;
			end
			if (!byte_stall) begin
				valid_s1 <= byte_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_q[0] <= ent_d[0];
		ent_q[1] <= ent_d[1];
		if (byte_valid && !byte_stall) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

endmodule

### hdl/utf8d_checker.sv
`timescale 1ns / 1ps
// utf8d_checker: port-level assertions for utf8_stream_decoder
// depends on utf8d_pkg; bound into utf8_stream_decoder below

module utf8d_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           result_valid,
	input logic                           result_stall,
	input logic [utf8d_pkg::CpWidth-1:0]  code_point,
	input utf8d_pkg::status_t             status,
	input logic                           last_of_run
);
	import utf8d_pkg::*;

	// error results never carry a value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |-> code_point == '0)
		else $error("error result with nonzero code point");

	// good results are scalar values
	a_ok_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_OK |->
		code_point < CpLimit && (code_point < SurrLo || code_point >= SurrHi))
		else $error("ok result outside scalar range");

	// a bad continuation that is not last is followed by the restart result
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last_of_run |=> result_valid)
		else $error("second result of an item missing");

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
		result_valid && $stable(code_point) && $stable(status) && $stable(last_of_run))
		else $error("stalled result changed");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.code_point   (code_point),
	.status       (status),
	.last_of_run  (last_of_run)
);
